>>> design/ibmcvt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IBM / IEEE float converter package
// Shared types, codes and helper functions for the word converter.
// ----------------------------------------------------------------------------
package ibmcvt_pkg;

    typedef logic [1:0] t_status;

    localparam t_status ST_NORMAL    = 2'd0;
    localparam t_status ST_NOT_IBM   = 2'd1;
    localparam t_status ST_SATURATED = 2'd2;
    localparam t_status ST_FLUSHED   = 2'd3;

    typedef logic t_cfg_idx;

    localparam t_cfg_idx CFG_DIRECTION = 1'b0;
    localparam t_cfg_idx CFG_SWAP      = 1'b1;

    localparam logic DIR_IEEE_TO_IBM = 1'b0;
    localparam logic DIR_IBM_TO_IEEE = 1'b1;

    localparam logic [31:0] SIGN_MASK      = 32'h8000_0000;
    localparam logic [30:0] IEEE_MAX_MAG   = 31'h7f7f_ffff;
    localparam logic [9:0]  IEEE_EXP_BIAS  = 10'd130;
    localparam logic signed [9:0] IEEE_EXP_MAX = 10'sd254;

    // Reverses the four bytes of a word.
    function automatic logic [31:0] byte_rev(input logic [31:0] w);
        byte_rev = {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    // Number of leading zeros of a 24-bit mantissa (nonzero input expected).
    function automatic logic [4:0] lead_zeros(input logic [23:0] m);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (m[i]) begin
                n = 5'(23 - i);
            end
        end
        lead_zeros = n;
    endfunction

endpackage

`default_nettype wire

>>> design/ibm_ieee_float_convert.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IBM hexadecimal float / IEEE single converter
// Three-stage pipeline converting one 32-bit word per transaction.
// ----------------------------------------------------------------------------
// The block takes one 32-bit word per cycle while its output is not stalled
// and returns the converted word through a three-stage register pipeline
// whose stages all advance together whenever the output register is empty
// or its word is being taken. It therefore sustains one word per clock
// cycle, and a stall on the output side holds every stage without losing or
// repeating a word. The direction register chooses IEEE single to IBM float
// (0) or IBM float to IEEE single (1); the swap register byte-reverses the
// word on the IBM side, that is the result for IEEE to IBM and the source for
// IBM to IEEE. Configuration must only be written while the pipeline is
// empty. The status on m_axis_tuser reports normal results, IBM words with a
// zero mantissa (passed on unchanged), values saturated to the largest finite
// IEEE value and values flushed to zero; IEEE to IBM always reports normal.
module ibm_ieee_float_convert
    import ibmcvt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire t_cfg_idx    i_cfg_idx,
    input  wire logic        i_cfg_wdata,

    // Input stream.
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] in_word
    input  wire logic        s_axis_tlast,   // is_last

    // Output stream.
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [31:0] m_axis_tdata,   // [31:0] out_word
    output      t_status     m_axis_tuser,   // [1:0] status
    output      logic        m_axis_tlast    // last_out
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic r_dir;
    logic r_swap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= DIR_IEEE_TO_IBM;
            r_swap <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DIRECTION: r_dir  <= i_cfg_wdata;
                CFG_SWAP:      r_swap <= i_cfg_wdata;
                default:       r_dir  <= r_dir;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. All stages move together; the pipeline advances
    // whenever the output register is free or being emptied.
    // ------------------------------------------------------------------
    logic w_adv;
    logic r_s1_valid, r_s2_valid, r_s3_valid;

    assign w_adv         = !r_s3_valid || m_axis_tready;
    assign s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= s_axis_tvalid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: bring an IBM source word into host byte order, classify it
    // and count the leading zeros of its mantissa.
    // ------------------------------------------------------------------
    logic [31:0] n_s1_word;
    logic [4:0]  n_s1_lz;

    logic [31:0] r_s1_word;
    logic [4:0]  r_s1_lz;
    logic        r_s1_zero;
    logic        r_s1_mzero;
    logic        r_s1_last;

    always_comb begin
        n_s1_word = (r_dir == DIR_IBM_TO_IEEE && r_swap) ? byte_rev(s_axis_tdata)
                                                         : s_axis_tdata;
        n_s1_lz   = lead_zeros(n_s1_word[23:0]);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_word  <= n_s1_word;
            r_s1_lz    <= n_s1_lz;
            r_s1_zero  <= (n_s1_word == 32'd0);
            r_s1_mzero <= (n_s1_word[23:0] == 24'd0);
            r_s1_last  <= s_axis_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the shifts and exponent arithmetic of both directions.
    // IEEE to IBM: the mantissa with its hidden bit is shifted right by k
    // so that the binary exponent becomes a multiple of four; the hex
    // exponent then falls out of (e + k + 130) / 4, taken modulo 128.
    // IBM to IEEE: the mantissa is normalised by its leading zero count and
    // the binary exponent is 4 * hex exponent - 130 - leading zeros.
    // ------------------------------------------------------------------
    logic [7:0]         n_s2_e;
    logic [1:0]         n_s2_k;
    logic [23:0]        n_s2_ibm_mant;
    logic [9:0]         n_s2_u;
    logic [31:0]        n_s2_ibm;
    logic [23:0]        n_s2_norm;
    logic signed [9:0]  n_s2_t;

    logic [31:0]        r_s2_ibm;
    logic [22:0]        r_s2_norm;
    logic signed [9:0]  r_s2_t;
    logic [31:0]        r_s2_word;
    logic               r_s2_zero;
    logic               r_s2_mzero;
    logic               r_s2_last;

    always_comb begin
        n_s2_e        = r_s1_word[30:23];
        n_s2_k        = 2'd2 - n_s2_e[1:0];
        n_s2_ibm_mant = {1'b1, r_s1_word[22:0]} >> n_s2_k;
        n_s2_u        = {2'b00, n_s2_e} + {8'd0, n_s2_k} + IEEE_EXP_BIAS;
        n_s2_ibm      = r_s1_zero ? 32'd0
                                  : {r_s1_word[31], n_s2_u[8:2], n_s2_ibm_mant};

        n_s2_norm     = r_s1_word[23:0] << r_s1_lz;
        n_s2_t        = $signed({1'b0, r_s1_word[30:24], 2'b00})
                      - $signed(IEEE_EXP_BIAS)
                      - $signed({5'd0, r_s1_lz});
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_ibm   <= n_s2_ibm;
            r_s2_norm  <= n_s2_norm[22:0];
            r_s2_t     <= n_s2_t;
            r_s2_word  <= r_s1_word;
            r_s2_zero  <= r_s1_zero;
            r_s2_mzero <= r_s1_mzero;
            r_s2_last  <= r_s1_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: range checks for IBM to IEEE, byte order of an IBM result,
    // and the output register.
    // ------------------------------------------------------------------
    logic [31:0] n_s3_word;
    t_status     n_s3_status;

    logic [31:0] r_s3_word;
    t_status     r_s3_status;
    logic        r_s3_last;

    always_comb begin
        n_s3_word   = 32'd0;
        n_s3_status = ST_NORMAL;
        if (r_dir == DIR_IEEE_TO_IBM) begin
            n_s3_word = r_swap ? byte_rev(r_s2_ibm) : r_s2_ibm;
        end else if (r_s2_zero) begin
            n_s3_word = 32'd0;
        end else if (r_s2_mzero) begin
            // A nonzero word without mantissa bits is not a valid IBM number.
            n_s3_word   = r_s2_word;
            n_s3_status = ST_NOT_IBM;
        end else if (r_s2_t > IEEE_EXP_MAX) begin
            n_s3_word   = (r_s2_word & SIGN_MASK) | {1'b0, IEEE_MAX_MAG};
            n_s3_status = ST_SATURATED;
        end else if (r_s2_t <= 10'sd0) begin
            n_s3_word   = 32'd0;
            n_s3_status = ST_FLUSHED;
        end else begin
            n_s3_word = {r_s2_word[31], r_s2_t[7:0], r_s2_norm};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_word   <= n_s3_word;
            r_s3_status <= n_s3_status;
            r_s3_last   <= r_s2_last;
        end
    end

    assign m_axis_tvalid = r_s3_valid;
    assign m_axis_tdata  = r_s3_word;
    assign m_axis_tuser  = r_s3_status;
    assign m_axis_tlast  = r_s3_last;

endmodule

`default_nettype wire

>>> tb/conv_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Float word conversion checker
// Predicts the converted word, status and end marker of every accepted input
// word and compares them with what the converter produces, in order.
// ----------------------------------------------------------------------------
package conv_check_pkg;

    import ibmcvt_pkg::*;

    typedef struct {
        logic [31:0] word;
        t_status     status;
        logic        last;
    } t_conv_result;

    localparam logic [30:0] LARGEST_FINITE = 31'h7f7f_ffff;

    function automatic logic [31:0] swap_bytes(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    class convert_checker;

        logic           dir;
        logic           swap;
        t_conv_result   expected_q[$];
        int unsigned    errors;

        function new();
            dir     = DIR_IEEE_TO_IBM;
            swap    = 1'b0;
            errors  = 0;
        endfunction

        function void set_reg(input t_cfg_idx idx, input logic value);
            if (idx == CFG_DIRECTION) begin
                dir = value;
            end else begin
                swap = value;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Converts one source word under the current direction and swap settings.
        function t_conv_result convert_word(input logic [31:0] src, input logic last);
            t_conv_result res;
            logic [31:0]  w;
            logic [23:0]  mant;
            logic [6:0]   hex_exp;
            int           bexp;
            int           shift;
            res.status = ST_NORMAL;
            res.last   = last;
            if (dir == DIR_IEEE_TO_IBM) begin
                w = src;
                if (w == 32'h0) begin
                    res.word = 32'h0;
                end else begin
                    // The hidden bit is always added, so denormals, infinities
                    // and NaNs come out as ordinary numbers.
                    bexp     = int'(w[30:23]) - 126;
                    shift    = (4 - (bexp & 3)) & 3;
                    mant     = {1'b1, w[22:0]} >> shift;
                    bexp     = bexp + shift;
                    hex_exp  = 7'(bexp / 4 + 64);
                    res.word = {w[31], hex_exp, mant};
                end
                if (swap) begin
                    res.word = swap_bytes(res.word);
                end
            end else begin
                w    = swap ? swap_bytes(src) : src;
                mant = w[23:0];
                if (w == 32'h0) begin
                    res.word = 32'h0;
                end else if (mant == 24'h0) begin
                    res.word   = w;
                    res.status = ST_NOT_IBM;
                end else begin
                    bexp = int'(w[30:24]) * 4 - 130;
                    while (!mant[23]) begin
                        bexp = bexp - 1;
                        mant = mant << 1;
                    end
                    if (bexp > 254) begin
                        res.word   = {w[31], LARGEST_FINITE};
                        res.status = ST_SATURATED;
                    end else if (bexp <= 0) begin
                        res.word   = 32'h0;
                        res.status = ST_FLUSHED;
                    end else begin
                        res.word = {w[31], 8'(bexp), mant[22:0]};
                    end
                end
            end
            return res;
        endfunction

        function void note_input(input logic [31:0] src, input logic last);
            expected_q.push_back(convert_word(src, last));
        endfunction

        task report_mismatch(input string what, input logic [31:0] got,
                             input logic [31:0] want);
            errors++;
            $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
        endtask

        task check_result(input logic [31:0] word, input t_status status,
                          input logic last);
            t_conv_result want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result word", word, 32'h0);
            end else begin
                want = expected_q.pop_front();
                if (word !== want.word) begin
                    report_mismatch("out_word", word, want.word);
                end
                if (status !== want.status) begin
                    report_mismatch("status", 32'(status), 32'(want.status));
                end
                if (last !== want.last) begin
                    report_mismatch("last_out", 32'(last), 32'(want.last));
                end
            end
        endtask

    endclass

endpackage

>>> tb/tb_ibm_ieee_float_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the IBM / IEEE float word converter
// Streams directed and random words through the converter under every
// direction and byte swap setting, with random idling on both sides, and
// checks each result word, status and end marker against a predictor.
// ----------------------------------------------------------------------------
module tb_ibm_ieee_float_convert;

    import ibmcvt_pkg::*;
    import conv_check_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 10;
    // The slowest correct run is roughly 1100 words plus one long receiver
    // hold; the limit leaves several times that.
    localparam int CYCLE_LIMIT      = 200000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int PHASE_WORDS      = 135;
    localparam int PHASE_COUNT      = 8;
    // The pipeline is three stages deep; the settle wait covers it.
    localparam int SETTLE_CYCLES    = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic        i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    t_status     m_axis_tuser;
    logic        m_axis_tlast;

    convert_checker conv_chk;

    // Idle odds in percent for each side, changed from phase to phase.
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    // Set by the stimulus to make the receiver hold off for a long stretch.
    bit          hold_request = 1'b0;
    int unsigned cycle_count = 0;

    ibm_ieee_float_convert uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [31:0] in_word
        .s_axis_tlast  (s_axis_tlast),    // is_last
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [31:0] out_word
        .m_axis_tuser  (m_axis_tuser),    // [1:0] status
        .m_axis_tlast  (m_axis_tlast)     // last_out
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // Watchdog: a run that hangs or loses results ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Both handshakes are observed in one block so that an input transaction
    // is always noted before any result at the same edge is checked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                conv_chk.note_input(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                conv_chk.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
        end
    end

    // Receiver. Each falling edge decides tready for the next cycle: either
    // a random stall burst, or the long hold when one is asked for, which
    // fills the pipeline so that the converter stalls its input.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD_CYCLES;
            end else if (stall_left == 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                stall_left = $urandom_range(1, 11);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offers one word and waits for its transaction, then possibly idles for
    // a burst. tvalid stays high when the next word follows straight away.
    task automatic send_word(input logic [31:0] word, input logic last);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            gap = $urandom_range(1, 11);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Stops offering words and waits until every expected result has come,
    // then lets the pipeline settle.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (conv_chk.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes are only issued with the pipeline empty.
    task automatic write_reg(input t_cfg_idx idx, input logic value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        conv_chk.set_reg(idx, value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Random source words, weighted towards the interesting corners of each
    // direction: zero and all-ones exponents for IEEE words; zero words, zero
    // mantissas, long normalisation runs and exponents near overflow and
    // underflow for IBM words. The byte swap applies to the IBM-side source.
    function automatic logic [31:0] rand_word(input logic dir, input logic swap);
        logic [31:0] w;
        w = $urandom();
        if (dir == DIR_IEEE_TO_IBM) begin
            case ($urandom_range(0, 9))
                0: w[30:23] = 8'h00;
                1: w[30:23] = 8'hff;
                2: w        = {w[31], 31'h0};
                default: ;
            endcase
        end else begin
            case ($urandom_range(0, 9))
                0: w          = 32'h0;
                1: w[23:0]    = 24'h0;
                2: w[23:0]    = w[23:0] >> $urandom_range(1, 23);
                3: w[30:24]   = 7'($urandom_range(94, 98));
                4: w[30:24]   = 7'($urandom_range(30, 34));
                default: ;
            endcase
            if (swap) begin
                w = swap_bytes(w);
            end
        end
        return w;
    endfunction

    // One phase of random words under one setting. It can ask for the long
    // receiver hold early on, and it can pause midway until the converter
    // has returned everything it was given.
    task automatic run_phase(input logic dir, input logic swap, input int words,
                             input bit long_hold, input bit pause_midway);
        drain();
        write_reg(CFG_DIRECTION, dir);
        write_reg(CFG_SWAP, swap);
        for (int i = 0; i < words; i++) begin
            if (long_hold && i == 10) begin
                hold_request = 1'b1;
            end
            if (pause_midway && i == words / 2) begin
                drain();
            end
            send_word(rand_word(dir, swap), $urandom_range(0, 7) == 0);
        end
    endtask

    initial begin
        logic [31:0] ieee_cases[$];
        logic [31:0] ibm_cases[$];
        logic        dir_sel;
        logic        swap_sel;

        conv_chk      = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_DIRECTION;
        i_cfg_wdata   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 32'h0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 20;
        rx_idle_pct = 20;

        // IEEE single to IBM, the setting after reset: zero and negative
        // zero, each residue of the exponent modulo four, denormals,
        // infinity, NaN, the largest finite value and the all-ones word.
        ieee_cases = '{32'h0000_0000, 32'h8000_0000, 32'h3f00_0000, 32'h3f80_0000,
                       32'h4000_0000, 32'h4080_0000, 32'h0000_0001, 32'h007f_ffff,
                       32'h7f7f_ffff, 32'h7f80_0000, 32'h7fc0_0000, 32'hffff_ffff};
        foreach (ieee_cases[i]) begin
            send_word(ieee_cases[i], 1'($urandom_range(0, 1)));
        end

        // IBM to IEEE single: zero, nonzero words with a zero mantissa, plus
        // and minus one, overflow on either sign, the largest exponent that
        // still fits, the smallest exponent that still fits and the first
        // one that flushes, and a mantissa needing a long normalisation.
        drain();
        write_reg(CFG_DIRECTION, DIR_IBM_TO_IEEE);
        ibm_cases = '{32'h0000_0000, 32'h8000_0000, 32'h4100_0000, 32'h4110_0000,
                      32'hc110_0000, 32'h0000_0001, 32'h7fff_ffff, 32'hffff_ffff,
                      32'h60ff_ffff, 32'h6110_0000, 32'h2140_0000, 32'h2120_0000,
                      32'h4000_0001};
        foreach (ibm_cases[i]) begin
            send_word(ibm_cases[i], 1'($urandom_range(0, 1)));
        end

        // Random phases: first every fixed setting, then random ones. Idle
        // odds vary per phase, sometimes to none, and the last phase runs
        // with no idling on either side at all.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin dir_sel = DIR_IEEE_TO_IBM; swap_sel = 1'b0; end
                1: begin dir_sel = DIR_IEEE_TO_IBM; swap_sel = 1'b1; end
                2: begin dir_sel = DIR_IBM_TO_IEEE; swap_sel = 1'b1; end
                3: begin dir_sel = DIR_IBM_TO_IEEE; swap_sel = 1'b0; end
                default: begin
                    dir_sel  = 1'($urandom_range(0, 1));
                    swap_sel = 1'($urandom_range(0, 1));
                end
            endcase
            if (p == PHASE_COUNT - 1) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = 10 * $urandom_range(0, 4);
                rx_idle_pct = 10 * $urandom_range(0, 4);
            end
            run_phase(dir_sel, swap_sel, PHASE_WORDS, p == 2, p == 4);
        end

        drain();
        if (conv_chk.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
